>>> hdl/qau_pkg.sv
// Shared types, constants and helper functions of the quaternion accumulator unit.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
package qau_pkg;

  localparam int COMPONENT_WIDTH  = 32;
  localparam int SAT_BITS         = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
  localparam int RSQRT_ITERATIONS = 3;
  localparam int DATA_W           = 32;
  localparam int MUL_W            = DATA_W + 1;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int ACC_W            = PROD_W + 2;
  localparam int STEP_W           = 4;

  localparam logic [DATA_W-1:0]        EPS_RESET = 32'd32;
  localparam logic signed [ACC_W-1:0]  Q_ONE     = ACC_W'(64'sh4000_0000);

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_MUL  = 3'd1,
    OP_ROT  = 3'd2,
    OP_ADDV = 3'd3,
    OP_NORM = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    MS_HAM, MS_WVEC, MS_SQ, MS_YY, MS_MY, MS_YH, MS_QY
  } msel_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_ACC, ACT_SQ, ACT_WVEC, ACT_Y2, ACT_MY2, ACT_YNEW, ACT_SCALE
  } act_t;

  typedef enum logic [2:0] {
    CM_LOAD, CM_HAM, CM_ADDV, CM_ONE, CM_NORM, CM_KEEP
  } commit_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_WVEC, ST_WGAP, ST_HAM, ST_DRAIN1, ST_DRAIN2,
    ST_SQ, ST_SQD1, ST_SQD2, ST_ZCHK, ST_SHIFT, ST_SEED,
    ST_NYY, ST_NYYW, ST_NMY, ST_NMYW, ST_NYH, ST_NYHW, ST_NSC, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic       take;
    msel_t      msel;
    logic [1:0] cidx;
    logic [1:0] tidx;
    act_t       act;
    logic       first;
    logic       last;
    logic       shift;
    logic       seed;
    logic       commit_en;
    commit_t    commit;
  } qau_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       zero_hit;
    logic       m_ok;
    logic       out_busy;
  } qau_sts_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
  } ham_term_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } clip_t;

  // Term t of Hamilton component c: a index, b index and sign.
  function automatic ham_term_t ham_term(input logic [1:0] c, input logic [1:0] t);
    ham_term_t r;
    unique case ({c, t})
      4'h0: r = '{2'd0, 2'd0, 1'b0};
      4'h1: r = '{2'd1, 2'd1, 1'b1};
      4'h2: r = '{2'd2, 2'd2, 1'b1};
      4'h3: r = '{2'd3, 2'd3, 1'b1};
      4'h4: r = '{2'd0, 2'd1, 1'b0};
      4'h5: r = '{2'd1, 2'd0, 1'b0};
      4'h6: r = '{2'd2, 2'd3, 1'b0};
      4'h7: r = '{2'd3, 2'd2, 1'b1};
      4'h8: r = '{2'd0, 2'd2, 1'b0};
      4'h9: r = '{2'd2, 2'd0, 1'b0};
      4'hA: r = '{2'd3, 2'd1, 1'b0};
      4'hB: r = '{2'd1, 2'd3, 1'b1};
      4'hC: r = '{2'd0, 2'd3, 1'b0};
      4'hD: r = '{2'd3, 2'd0, 1'b0};
      4'hE: r = '{2'd1, 2'd2, 1'b0};
      4'hF: r = '{2'd2, 2'd1, 1'b1};
    endcase
    return r;
  endfunction

  // Starting value of the reciprocal square root, Q2.30.
  function automatic logic [DATA_W-1:0] rsq_seed(input logic [2:0] idx);
    logic [DATA_W-1:0] r;
    unique case (idx)
      3'd0, 3'd1, 3'd2: r = 32'd960383883;
      3'd3:             r = 32'd811672527;
      3'd4:             r = 32'd715827883;
      3'd5:             r = 32'd647490680;
      3'd6:             r = 32'd595604800;
      3'd7:             r = 32'd554477895;
    endcase
    return r;
  endfunction

  // Saturate to the signed component range and report clipping.
  function automatic clip_t clip_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    clip_t r;
    hi = {{(ACC_W-SAT_BITS+1){1'b0}}, {(SAT_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = '{1'b1, hi[DATA_W-1:0]};
    end else if (v < lo) begin
      r = '{1'b1, lo[DATA_W-1:0]};
    end else begin
      r = '{1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

>>> hdl/qau_in_if.sv
// Input channel of the quaternion accumulator unit: valid, ready and one item.
// Depends on nothing.
interface qau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] operand_w;
  logic signed [31:0] operand_x;
  logic signed [31:0] operand_y;
  logic signed [31:0] operand_z;
  logic signed [31:0] scale;

  modport source (output valid, operation, operand_w, operand_x, operand_y, operand_z, scale,
                  input ready);
  modport sink (input valid, operation, operand_w, operand_x, operand_y, operand_z, scale,
                output ready);
endinterface

>>> hdl/qau_out_if.sv
// Result channel of the quaternion accumulator unit: valid, ready and one item.
// Depends on nothing.
interface qau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_r;
  logic signed [31:0] out_i;
  logic signed [31:0] out_j;
  logic signed [31:0] out_k;
  logic               zero_length;
  logic               saturated;

  modport source (output valid, out_r, out_i, out_j, out_k, zero_length, saturated,
                  input ready);
  modport sink (input valid, out_r, out_i, out_j, out_k, zero_length, saturated,
                output ready);
endinterface

>>> hdl/qau_ctrl.sv
// Controller of the quaternion accumulator unit: sequences the shared multiplier.
// Depends on qau_pkg.
module qau_ctrl #(
  parameter int RSQRT_ITERATIONS = qau_pkg::RSQRT_ITERATIONS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qau_pkg::qau_sts_t sts,
  output qau_pkg::qau_cmd_t cmd
);

  localparam int IW = $clog2(RSQRT_ITERATIONS + 1);

  qau_pkg::state_t             state_r, state_nxt;
  logic [qau_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [IW-1:0]               iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qau_pkg::ST_IDLE;
      step_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      qau_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = qau_pkg::ST_DECODE;
      end
      qau_pkg::ST_DECODE: begin
        case (sts.op)
          qau_pkg::OP_MUL, qau_pkg::OP_ROT: state_nxt = qau_pkg::ST_HAM;
          qau_pkg::OP_ADDV:                 state_nxt = qau_pkg::ST_WVEC;
          qau_pkg::OP_NORM:                 state_nxt = qau_pkg::ST_SQ;
          default:                          state_nxt = qau_pkg::ST_COMMIT;
        endcase
      end
      qau_pkg::ST_WVEC:   if (step_r == 4'd2) state_nxt = qau_pkg::ST_WGAP;
      qau_pkg::ST_WGAP:   state_nxt = qau_pkg::ST_HAM;
      qau_pkg::ST_HAM:    if (step_r == 4'd15) state_nxt = qau_pkg::ST_DRAIN1;
      qau_pkg::ST_DRAIN1: state_nxt = qau_pkg::ST_DRAIN2;
      qau_pkg::ST_DRAIN2: state_nxt = qau_pkg::ST_COMMIT;
      qau_pkg::ST_SQ:     if (step_r == 4'd3) state_nxt = qau_pkg::ST_SQD1;
      qau_pkg::ST_SQD1:   state_nxt = qau_pkg::ST_SQD2;
      qau_pkg::ST_SQD2:   state_nxt = qau_pkg::ST_ZCHK;
      qau_pkg::ST_ZCHK: begin
        if (!sts.zero_hit) begin
          state_nxt = qau_pkg::ST_SHIFT;
        end else if (!sts.out_busy) begin
          state_nxt = qau_pkg::ST_IDLE;
        end
      end
      qau_pkg::ST_SHIFT:  if (sts.m_ok) state_nxt = qau_pkg::ST_SEED;
      qau_pkg::ST_SEED: begin
        state_nxt = qau_pkg::ST_NYY;
        iter_nxt  = '0;
      end
      qau_pkg::ST_NYY:    state_nxt = qau_pkg::ST_NYYW;
      qau_pkg::ST_NYYW:   state_nxt = qau_pkg::ST_NMY;
      qau_pkg::ST_NMY:    state_nxt = qau_pkg::ST_NMYW;
      qau_pkg::ST_NMYW:   state_nxt = qau_pkg::ST_NYH;
      qau_pkg::ST_NYH:    state_nxt = qau_pkg::ST_NYHW;
      qau_pkg::ST_NYHW: begin
        if (iter_r == IW'(RSQRT_ITERATIONS - 1)) begin
          state_nxt = qau_pkg::ST_NSC;
        end else begin
          state_nxt = qau_pkg::ST_NYY;
          iter_nxt  = iter_r + 1'b1;
        end
      end
      qau_pkg::ST_NSC:    if (step_r == 4'd3) state_nxt = qau_pkg::ST_DRAIN1;
      qau_pkg::ST_COMMIT: if (!sts.out_busy) state_nxt = qau_pkg::ST_IDLE;
      default:            state_nxt = qau_pkg::ST_IDLE;
    endcase
    step_nxt = (state_nxt == state_r) ? step_r + 1'b1 : '0;
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.msel     = qau_pkg::MS_HAM;
    cmd.act      = qau_pkg::ACT_NONE;
    cmd.commit   = qau_pkg::CM_KEEP;
    in_ready     = 1'b0;
    unique case (state_r)
      qau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      qau_pkg::ST_WVEC: begin
        cmd.msel = qau_pkg::MS_WVEC;
        cmd.cidx = step_r[1:0] + 2'd1;
        cmd.act  = qau_pkg::ACT_WVEC;
      end
      qau_pkg::ST_HAM: begin
        cmd.msel  = qau_pkg::MS_HAM;
        cmd.cidx  = step_r[3:2];
        cmd.tidx  = step_r[1:0];
        cmd.act   = qau_pkg::ACT_ACC;
        cmd.first = (step_r[1:0] == 2'd0);
        cmd.last  = (step_r[1:0] == 2'd3);
      end
      qau_pkg::ST_SQ: begin
        cmd.msel  = qau_pkg::MS_SQ;
        cmd.cidx  = step_r[1:0];
        cmd.act   = qau_pkg::ACT_SQ;
        cmd.first = (step_r[1:0] == 2'd0);
        cmd.last  = (step_r[1:0] == 2'd3);
      end
      qau_pkg::ST_ZCHK: begin
        cmd.commit    = qau_pkg::CM_ONE;
        cmd.commit_en = sts.zero_hit && !sts.out_busy;
      end
      qau_pkg::ST_SHIFT: cmd.shift = !sts.m_ok;
      qau_pkg::ST_SEED:  cmd.seed  = 1'b1;
      qau_pkg::ST_NYY: begin
        cmd.msel = qau_pkg::MS_YY;
        cmd.act  = qau_pkg::ACT_Y2;
      end
      qau_pkg::ST_NMY: begin
        cmd.msel = qau_pkg::MS_MY;
        cmd.act  = qau_pkg::ACT_MY2;
      end
      qau_pkg::ST_NYH: begin
        cmd.msel = qau_pkg::MS_YH;
        cmd.act  = qau_pkg::ACT_YNEW;
      end
      qau_pkg::ST_NSC: begin
        cmd.msel = qau_pkg::MS_QY;
        cmd.cidx = step_r[1:0];
        cmd.act  = qau_pkg::ACT_SCALE;
      end
      qau_pkg::ST_COMMIT: begin
        cmd.commit_en = !sts.out_busy;
        case (sts.op)
          qau_pkg::OP_LOAD:                 cmd.commit = qau_pkg::CM_LOAD;
          qau_pkg::OP_MUL, qau_pkg::OP_ROT: cmd.commit = qau_pkg::CM_HAM;
          qau_pkg::OP_ADDV:                 cmd.commit = qau_pkg::CM_ADDV;
          qau_pkg::OP_NORM:                 cmd.commit = qau_pkg::CM_NORM;
          default:                          cmd.commit = qau_pkg::CM_KEEP;
        endcase
      end
      default: ;
    endcase
  end

  a_take_closes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !in_ready)
    else $error("input still open after an item was taken");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_en |-> !sts.out_busy)
    else $error("result committed over an untaken result");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= IW'(RSQRT_ITERATIONS - 1))
    else $error("Newton iteration count out of range");

endmodule

>>> hdl/qau_dp.sv
// Datapath of the quaternion accumulator unit: state, shared multiplier,
// accumulator, normalise registers and the output register. Depends on qau_pkg.
module qau_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  qau_pkg::qau_cmd_t  cmd,
  output qau_pkg::qau_sts_t  sts,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_w,
  input  logic signed [31:0] in_operand_x,
  input  logic signed [31:0] in_operand_y,
  input  logic signed [31:0] in_operand_z,
  input  logic signed [31:0] in_scale,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_r,
  output logic signed [31:0] out_i,
  output logic signed [31:0] out_j,
  output logic signed [31:0] out_k,
  output logic               out_zero_length,
  output logic               out_saturated
);

  localparam int DW = qau_pkg::DATA_W;
  localparam int MW = qau_pkg::MUL_W;
  localparam int PW = qau_pkg::PROD_W;
  localparam int AW = qau_pkg::ACC_W;
  localparam logic signed [AW-1:0] HALF15 = AW'(64'sd1 << 15);
  localparam logic signed [AW-1:0] HALF16 = AW'(64'sd1 << 16);
  localparam logic signed [AW-1:0] HALF29 = AW'(64'sd1 << 29);
  localparam logic [35:0]          THREE_Q = 36'h0_C000_0000;
  localparam qau_pkg::clip_t       ONE_CLIP = qau_pkg::clip_sat(qau_pkg::Q_ONE);

  logic [2:0]               op_r;
  logic signed [DW-1:0]     opnd_r [4];
  logic signed [DW-1:0]     scale_r;
  logic signed [DW-1:0]     quat_r [4];
  logic signed [DW-1:0]     w_r [4];
  logic [DW-1:0]            eps_r;
  logic signed [PW-1:0]     prod_r;
  qau_pkg::act_t            p_act_r;
  logic                     p_neg_r, p_first_r, p_last_r;
  logic [1:0]               p_idx_r;
  logic signed [AW-1:0]     acc_r;
  logic                     a_last_r;
  logic [1:0]               a_idx_r;
  logic signed [AW-1:0]     res_r [4];
  logic [63:0]              d_r;
  logic signed [6:0]        s_r;
  logic [DW-1:0]            y_r, t_r;
  logic                     sat_r;
  logic                     out_valid_r, out_zero_r, out_sat_r;
  logic signed [DW-1:0]     out_q_r [4];

  qau_pkg::ham_term_t       term;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [AW-1:0]     prod_x, acc_base, round_h, scale_half, wv_sum;
  logic [5:0]               scale_sh;
  logic [35:0]              my2;
  qau_pkg::clip_t           wv_clip;
  logic signed [DW-1:0]     commit_q [4];
  logic                     commit_sat, commit_zero;
  qau_pkg::clip_t           cq [4];

  // Operand selection for the shared multiplier.
  always_comb begin
    term  = qau_pkg::ham_term(cmd.cidx, cmd.tidx);
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.msel)
      qau_pkg::MS_HAM: begin
        if (op_r == qau_pkg::OP_ADDV) begin
          mul_a = MW'(w_r[term.ia]);
          mul_b = MW'(quat_r[term.ib]);
        end else begin
          mul_a = MW'(quat_r[term.ia]);
          // Rotation treats the operand as a pure vector.
          mul_b = (op_r == qau_pkg::OP_ROT && term.ib == 2'd0) ? '0 : MW'(opnd_r[term.ib]);
        end
      end
      qau_pkg::MS_WVEC: begin
        mul_a = MW'(opnd_r[cmd.cidx]);
        mul_b = MW'(scale_r);
      end
      qau_pkg::MS_SQ: begin
        mul_a = MW'(quat_r[cmd.cidx]);
        mul_b = MW'(quat_r[cmd.cidx]);
      end
      qau_pkg::MS_YY: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      qau_pkg::MS_MY: begin
        mul_a = {1'b0, d_r[DW-1:0]};
        mul_b = {1'b0, t_r};
      end
      qau_pkg::MS_YH: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, t_r};
      end
      qau_pkg::MS_QY: begin
        mul_a = MW'(quat_r[cmd.cidx]);
        mul_b = {1'b0, y_r};
      end
      default: ;
    endcase
  end

  // Second stage arithmetic on the registered product.
  always_comb begin
    prod_x     = AW'(prod_r);
    acc_base   = p_first_r ? '0 : acc_r;
    wv_sum     = (prod_x + HALF15) >>> 16;
    wv_clip    = qau_pkg::clip_sat(wv_sum);
    my2        = prod_r[65:30];
    scale_sh   = 6'(7'sd16 + (s_r >>> 1));
    scale_half = AW'(1) <<< (scale_sh - 6'd1);
    case (op_r)
      qau_pkg::OP_MUL: round_h = (acc_r + HALF29) >>> 30;
      qau_pkg::OP_ROT: round_h = (acc_r + HALF15) >>> 16;
      default:         round_h = (acc_r + HALF16) >>> 17;
    endcase
  end

  // New state at the end of an item.
  always_comb begin
    commit_sat  = 1'b0;
    commit_zero = 1'b0;
    for (int c = 0; c < 4; c++) begin
      cq[c] = '{1'b0, quat_r[c]};
      unique case (cmd.commit)
        qau_pkg::CM_LOAD:            cq[c] = qau_pkg::clip_sat(AW'(opnd_r[c]));
        qau_pkg::CM_HAM,
        qau_pkg::CM_NORM:            cq[c] = qau_pkg::clip_sat(res_r[c]);
        qau_pkg::CM_ADDV:            cq[c] = qau_pkg::clip_sat(AW'(quat_r[c]) + res_r[c]);
        qau_pkg::CM_ONE:             if (c == 0) cq[c] = ONE_CLIP;
        default: ;
      endcase
      commit_q[c] = cq[c].val;
      commit_sat  = commit_sat | cq[c].sat;
    end
    if (cmd.commit == qau_pkg::CM_ONE) commit_zero = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0]   <= ONE_CLIP.val;
      quat_r[1]   <= '0;
      quat_r[2]   <= '0;
      quat_r[3]   <= '0;
      eps_r       <= qau_pkg::EPS_RESET;
      p_act_r     <= qau_pkg::ACT_NONE;
      a_last_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) eps_r <= cfg_wdata;
      p_act_r  <= cmd.act;
      a_last_r <= p_last_r && (p_act_r == qau_pkg::ACT_ACC || p_act_r == qau_pkg::ACT_SQ);
      if (cmd.commit_en) begin
        quat_r      <= commit_q;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= PW'(mul_a * mul_b);
    p_neg_r   <= term.neg;
    p_first_r <= cmd.first;
    p_last_r  <= cmd.last;
    p_idx_r   <= cmd.cidx;
    a_idx_r   <= p_idx_r;

    if (cmd.take) begin
      op_r      <= in_operation;
      opnd_r[0] <= in_operand_w;
      opnd_r[1] <= in_operand_x;
      opnd_r[2] <= in_operand_y;
      opnd_r[3] <= in_operand_z;
      scale_r   <= in_scale;
      w_r[0]    <= '0;
      sat_r     <= 1'b0;
    end

    unique case (p_act_r)
      qau_pkg::ACT_ACC:   acc_r <= acc_base + (p_neg_r ? -prod_x : prod_x);
      qau_pkg::ACT_SQ:    acc_r <= acc_base + (prod_x >>> 2);
      qau_pkg::ACT_WVEC: begin
        w_r[p_idx_r] <= wv_clip.val;
        if (wv_clip.sat) sat_r <= 1'b1;
      end
      qau_pkg::ACT_Y2:    t_r <= prod_r[61:30];
      qau_pkg::ACT_MY2:   t_r <= (my2 >= THREE_Q) ? '0 : DW'(THREE_Q - my2);
      qau_pkg::ACT_YNEW:  y_r <= prod_r[62:31];
      qau_pkg::ACT_SCALE: res_r[p_idx_r] <= (prod_x + scale_half) >>> scale_sh;
      default: ;
    endcase

    if (a_last_r) begin
      if (op_r == qau_pkg::OP_NORM) begin
        d_r <= acc_r[63:0];
        s_r <= '0;
      end else begin
        res_r[a_idx_r] <= round_h;
      end
    end

    // Bring the squared norm into [1, 4) by even shifts.
    if (cmd.shift) begin
      if (d_r[63:32] != '0) begin
        d_r <= d_r >> 2;
        s_r <= s_r + 7'sd2;
      end else begin
        d_r <= d_r << 2;
        s_r <= s_r - 7'sd2;
      end
    end
    if (cmd.seed) y_r <= qau_pkg::rsq_seed(d_r[29:27]);

    if (cmd.commit_en) begin
      out_q_r    <= commit_q;
      out_zero_r <= commit_zero;
      out_sat_r  <= sat_r | commit_sat;
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.zero_hit = (d_r == '0) || (d_r < {2'b00, eps_r, 30'b0});
    sts.m_ok     = (d_r[63:32] == '0) && (d_r[31:30] != 2'b00);
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_r           = out_q_r[0];
  assign out_i           = out_q_r[1];
  assign out_j           = out_q_r[2];
  assign out_k           = out_q_r[3];
  assign out_zero_length = out_zero_r;
  assign out_saturated   = out_sat_r;

  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed |-> (d_r[63:32] == '0) && (d_r[31:30] != 2'b00))
    else $error("reciprocal root seeded from an unnormalised value");

endmodule

>>> hdl/quaternion_accumulator_unit.sv
// Top level of the quaternion accumulator unit: controller plus datapath.
// Depends on qau_pkg, qau_in_if, qau_out_if, qau_ctrl and qau_dp.
//
//  channel  | direction | handshake      | content
//  in_ch    | in        | valid / ready  | operation, operand_w/x/y/z, scale
//  out_ch   | out       | valid / ready  | out_r/i/j/k, zero_length, saturated
//  cfg_     | in        | cfg_we         | epsilon_threshold (cfg_wdata)
//
// One item at a time through one shared 33x33 multiplier, one product a cycle.
// Normalise runs longer with more Newton iterations (RSQRT_ITERATIONS) and with each
// even shift of the norm (up to 16 shifts), and it ends early when the norm is below
// epsilon.
// Reset is synchronous; it restores the unit quaternion and epsilon 32.
// A finished result waits in the output register while the next item is taken;
// a second result waits for the first to be taken.
module quaternion_accumulator_unit #(
  parameter int RSQRT_ITERATIONS = qau_pkg::RSQRT_ITERATIONS
) (
  input  logic       clk,
  input  logic       rst_n,
  qau_in_if.sink     in_ch,
  qau_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [31:0] cfg_wdata
);

  qau_pkg::qau_cmd_t cmd;
  qau_pkg::qau_sts_t sts;

  qau_ctrl #(
    .RSQRT_ITERATIONS (RSQRT_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qau_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_operand_w    (in_ch.operand_w),
    .in_operand_x    (in_ch.operand_x),
    .in_operand_y    (in_ch.operand_y),
    .in_operand_z    (in_ch.operand_z),
    .in_scale        (in_ch.scale),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_r           (out_ch.out_r),
    .out_i           (out_ch.out_i),
    .out_j           (out_ch.out_j),
    .out_k           (out_ch.out_k),
    .out_zero_length (out_ch.zero_length),
    .out_saturated   (out_ch.saturated)
  );

endmodule
